@@ hw/rtl/lmfb_pkg.sv @@
// lmfb_pkg: shared constants and types for the led matrix frame buffer
// no dependencies; imported by every lmfb module and the top level
package lmfb_pkg;

  localparam int MATRIX_SIDE = 5;
  localparam int LED_TOTAL   = MATRIX_SIDE * MATRIX_SIDE;
  localparam int IDX_W       = $clog2(LED_TOTAL);

  localparam int COORD_W = 3;
  localparam int CHAN_W  = 8;
  localparam int GRB_W   = 3 * CHAN_W;
  localparam int PROD_W  = 2 * CHAN_W;
  localparam int IN_DATA_W  = 16;
  localparam int OUT_DATA_W = 24;
  localparam int CFG_IDX_W  = 2;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COLOR_RED   = 2'd0,
    REG_COLOR_GREEN = 2'd1,
    REG_COLOR_BLUE  = 2'd2
  } cfg_reg_t;

  typedef enum logic {
    REQ_SET   = 1'b0,
    REQ_FLUSH = 1'b1
  } req_type_t;

  typedef struct packed {
    logic shift;
    logic write;
  } cell_ctl_t;

endpackage

@@ hw/rtl/led_matrix_frame_buffer.sv @@
// led_matrix_frame_buffer: frame buffer for a square serpentine led matrix
// depends on lmfb_pkg, lmfb_cell, lmfb_scale
//
// usage:
//   input stream in_*: in_tuser selects set (0) or flush (1); in_tdata holds
//   col, row and intensity. config port cfg_* writes the theme color (red,
//   green, blue at indexes 0..2, other indexes ignored); the user writes it
//   only while idle, not enforced by the block. output stream out_*: a flush
//   emits one grb word per led in chain order, out_tlast high on the final word.
// set and flush:
//   a set registers the products of the multipliers, then the scaled color
//   is written into the addressed cell. sets with a coordinate outside the
//   matrix are dropped.
//   a flush rotates the ring of cells once, one word per cycle while the
//   receiver accepts; the first word appears once the state register moves to
//   flush and the output register loads it. after the ring returns to place the
//   next item is taken even while the final word still waits in the output
//   register.
// reset: synchronous, clears every pixel to black and sets the color to red.
// stall: while out_tready is low the ring holds still and the word waits.
module led_matrix_frame_buffer (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [lmfb_pkg::IN_DATA_W-1:0]  in_tdata,   // col[2:0], row[5:3], intensity[13:6]
  input  logic                            in_tuser,   // req_type
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [lmfb_pkg::OUT_DATA_W-1:0] out_tdata,  // grb_word[23:0]
  output logic                            out_tlast,
  input  logic                            cfg_we,
  input  logic [lmfb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lmfb_pkg::CHAN_W-1:0]     cfg_wdata
);
  import lmfb_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SET,
    ST_FLUSH
  } state_t;

  localparam logic [COORD_W:0] SIDE_C = (COORD_W+1)'(MATRIX_SIDE);
  localparam logic [IDX_W-1:0] SIDE_I = IDX_W'(MATRIX_SIDE);
  localparam logic [IDX_W-1:0] LAST_I = IDX_W'(LED_TOTAL - 1);

  state_t              state_r;
  logic [CHAN_W-1:0]   red_r, green_r, blue_r;
  logic [IDX_W-1:0]    pos_r;
  logic [IDX_W-1:0]    cnt_r;
  logic                out_valid_r;
  logic [GRB_W-1:0]    out_data_r;
  logic                out_last_r;

  logic [COORD_W-1:0]  col, row;
  logic [CHAN_W-1:0]   level;
  logic                in_acc, in_range, load_out;
  logic [IDX_W-1:0]    along, pos_nxt;
  logic [GRB_W-1:0]    scaled;
  logic [GRB_W-1:0]    cell_pix [LED_TOTAL];

  assign col   = in_tdata[COORD_W-1:0];
  assign row   = in_tdata[2*COORD_W-1:COORD_W];
  assign level = in_tdata[2*COORD_W +: CHAN_W];

  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;
  assign in_range  = ({1'b0, col} < SIDE_C) && ({1'b0, row} < SIDE_C);
  assign along     = row[0] ? (SIDE_I - IDX_W'(1) - IDX_W'(col)) : IDX_W'(col);
  assign pos_nxt   = LAST_I - (IDX_W'(row) * SIDE_I + along);
  assign load_out  = (state_r == ST_FLUSH) && (!out_valid_r || out_tready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      red_r   <= 8'd255;
      green_r <= '0;
      blue_r  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_COLOR_RED:   red_r   <= cfg_wdata;
        REG_COLOR_GREEN: green_r <= cfg_wdata;
        REG_COLOR_BLUE:  blue_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  lmfb_scale u_scale (
    .clk   (clk),
    .en    (in_acc),
    .red   (red_r),
    .green (green_r),
    .blue  (blue_r),
    .level (level),
    .grb   (scaled)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
      out_last_r  <= 1'b0;
    end else begin
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_tvalid && out_tready) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (in_acc) begin
            if (in_tuser == REQ_FLUSH) begin
              state_r <= ST_FLUSH;
              cnt_r   <= '0;
            end else if (in_range) begin
              state_r <= ST_SET;
            end
          end
        end
        ST_SET: begin
          state_r <= ST_IDLE;
        end
        ST_FLUSH: begin
          if (load_out) begin
            out_last_r  <= (cnt_r == LAST_I);
            cnt_r       <= cnt_r + IDX_W'(1);
            if (cnt_r == LAST_I) begin
              state_r <= ST_IDLE;
            end
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      pos_r <= pos_nxt;
    end
    if (load_out) begin
      out_data_r <= cell_pix[0];
    end
  end

  for (genvar k = 0; k < LED_TOTAL; k++) begin : g_cell
    cell_ctl_t ctl;
    assign ctl.shift = load_out;
    assign ctl.write = (state_r == ST_SET) && (pos_r == IDX_W'(k));

    lmfb_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .wr_data  (scaled),
      .nbr_data (cell_pix[(k + 1) % LED_TOTAL]),
      .pix      (cell_pix[k])
    );
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tlast  = out_last_r;

endmodule

@@ hw/rtl/lmfb_cell.sv @@
// lmfb_cell: one pixel of the serpentine chain, loads a new color or its neighbor
// depends on lmfb_pkg
module lmfb_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  lmfb_pkg::cell_ctl_t       ctl,
  input  logic [lmfb_pkg::GRB_W-1:0] wr_data,
  input  logic [lmfb_pkg::GRB_W-1:0] nbr_data,
  output logic [lmfb_pkg::GRB_W-1:0] pix
);
  import lmfb_pkg::*;

  logic [GRB_W-1:0] pix_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pix_r <= '0;
    end else if (ctl.write) begin
      pix_r <= wr_data;
    end else if (ctl.shift) begin
      pix_r <= nbr_data;
    end
  end

  assign pix = pix_r;

endmodule

@@ hw/rtl/lmfb_scale.sv @@
// lmfb_scale: scales the theme color by an intensity, floor(c * i / 255) per channel
// depends on lmfb_pkg; products registered, divide by 255 after the register
module lmfb_scale (
  input  logic                        clk,
  input  logic                        en,
  input  logic [lmfb_pkg::CHAN_W-1:0] red,
  input  logic [lmfb_pkg::CHAN_W-1:0] green,
  input  logic [lmfb_pkg::CHAN_W-1:0] blue,
  input  logic [lmfb_pkg::CHAN_W-1:0] level,
  output logic [lmfb_pkg::GRB_W-1:0]  grb
);
  import lmfb_pkg::*;

  logic [PROD_W-1:0] prod_r_r;
  logic [PROD_W-1:0] prod_g_r;
  logic [PROD_W-1:0] prod_b_r;

  // exact x / 255 for x <= 255 * 255
  function automatic logic [CHAN_W-1:0] div255(input logic [PROD_W-1:0] x);
    logic [PROD_W:0] s;
    s = {1'b0, x} + (PROD_W+1)'(x >> CHAN_W) + (PROD_W+1)'(1);
    return s[CHAN_W +: CHAN_W];
  endfunction

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r_r <= PROD_W'(red)   * PROD_W'(level);
      prod_g_r <= PROD_W'(green) * PROD_W'(level);
      prod_b_r <= PROD_W'(blue)  * PROD_W'(level);
    end
  end

  assign grb = {div255(prod_g_r), div255(prod_r_r), div255(prod_b_r)};

endmodule
